// ----- design/mts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the max Tanimoto similarity core.
// No dependencies; every other design file refers to this package.
package mts_pkg;

  localparam int unsigned CHUNKS_DEF      = 16;
  localparam int unsigned MAX_TARGETS_DEF = 16;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned UNION_W  = 12;  // sum of two bit counts
  localparam int unsigned FRAC_W   = 16;  // Q1.16 fraction bits
  localparam int unsigned SIM_W    = 17;
  localparam int unsigned TOTAL_W  = 5;
  localparam int unsigned POP_W    = 7;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_TARGET = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CAPT,
    ST_SHIFT,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [WORD_W-1:0]  word;
    logic               last;
    logic [COUNT_W-1:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic [SIM_W-1:0]   similarity;
    logic [TOTAL_W-1:0] targets_compared;
    logic               dropped;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic wr_word;
    logic wr_count;
    logic query;
    logic capture;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic init;
    logic cmp;
    logic div_init;
    logic div_step;
  } fin_ctrl_t;

  // Population count of one chunk: per-byte counts, then a sum of eight bytes.
  function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
    logic [3:0]       b [8];
    logic [POP_W-1:0] s;
    for (int i = 0; i < 8; i++) begin
      b[i] = 4'd0;
      for (int j = 0; j < 8; j++) begin
        b[i] = b[i] + 4'(v[i*8+j]);
      end
    end
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + POP_W'(b[i]);
    end
    return s;
  endfunction

endpackage

// ----- design/mts_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream interfaces for input chunks and similarity results.
// Depends on mts_pkg for the payload types.
interface mts_in_if;
  logic              valid;
  logic              ready;
  mts_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mts_out_if;
  logic               valid;
  logic               ready;
  mts_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/mts_cell.sv -----
`timescale 1ns / 1ps
// One target cell: stores a target fingerprint, its count and its AND accumulator,
// and hands its (AND count, union) pair to the neighbor during the reduction walk.
module mts_cell #(
  parameter int unsigned CHUNKS = mts_pkg::CHUNKS_DEF,
  localparam int unsigned CIW   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1,
  localparam int unsigned AW    = $clog2(CHUNKS * mts_pkg::WORD_W + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mts_pkg::cell_ctrl_t          ctrl_i,
  input  logic                         sel_i,
  input  logic                         active_i,
  input  logic [CIW-1:0]               wr_idx_i,
  input  logic [CIW-1:0]               rd_idx_i,
  input  logic [mts_pkg::WORD_W-1:0]   word_i,
  input  logic [mts_pkg::COUNT_W-1:0]  count_i,
  input  logic [mts_pkg::COUNT_W-1:0]  qcount_i,
  input  logic [AW-1:0]                num_i,
  input  logic [mts_pkg::UNION_W-1:0]  den_i,
  output logic [AW-1:0]                num_o,
  output logic [mts_pkg::UNION_W-1:0]  den_o
);

  localparam int unsigned UW  = mts_pkg::UNION_W;
  localparam int unsigned CW  = ((UW > AW) ? UW : AW) + 1;

  logic [mts_pkg::WORD_W-1:0]  words_q [CHUNKS];
  logic [CHUNKS-1:0]           valid_q;
  logic [mts_pkg::COUNT_W-1:0] count_q;
  logic [AW-1:0]               acc_q;
  logic [AW-1:0]               num_q;
  logic [UW-1:0]               den_q;

  logic [mts_pkg::WORD_W-1:0]  rd_word;
  logic [CW-1:0]               sum_w;
  logic [CW-1:0]               acc_w;

  assign rd_word = valid_q[rd_idx_i] ? words_q[rd_idx_i] : '0;
  assign sum_w   = CW'(qcount_i) + CW'(count_q);
  assign acc_w   = CW'(acc_q);

  // Write chunk storage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_word && sel_i) begin
      words_q[wr_idx_i] <= word_i;
    end
  end

  // Track written chunks; unwritten ones read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.clear) begin
      valid_q <= '0;
    end else if (ctrl_i.wr_word && sel_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  // Hold target count and accumulate AND bit counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      acc_q   <= '0;
    end else if (ctrl_i.clear) begin
      count_q <= '0;
      acc_q   <= '0;
    end else begin
      if (ctrl_i.wr_count && sel_i) begin
        count_q <= count_i;
      end
      if (ctrl_i.capture) begin
        acc_q <= '0;
      end else if (ctrl_i.query && active_i) begin
        acc_q <= acc_q + AW'(mts_pkg::pop64(word_i & rd_word));
      end
    end
  end

  // Load own pair on capture, then pass neighbor's pair along
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      if (!active_i || (sum_w <= acc_w)) begin
        num_q <= '0;
        den_q <= UW'(1);
      end else begin
        num_q <= acc_q;
        den_q <= UW'(sum_w - acc_w);
      end
    end else if (ctrl_i.shift) begin
      num_q <= num_i;
      den_q <= den_i;
    end
  end

  assign num_o = num_q;
  assign den_o = den_q;

endmodule

// ----- design/mts_finish.sv -----
`timescale 1ns / 1ps
// Reduction end of the cell chain: keeps the largest fraction by cross
// multiplication, then divides it once, one quotient bit per cycle. Uses mts_pkg.
module mts_finish #(
  parameter int unsigned AW = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mts_pkg::fin_ctrl_t           ctrl_i,
  input  logic [AW-1:0]                num_i,
  input  logic [mts_pkg::UNION_W-1:0]  den_i,
  output logic [mts_pkg::SIM_W-1:0]    quo_o
);

  localparam int unsigned UW = mts_pkg::UNION_W;
  localparam int unsigned PW = AW + UW;
  localparam int unsigned FW = mts_pkg::FRAC_W;

  logic [AW-1:0] best_num_q;
  logic [UW-1:0] best_den_q;
  logic [UW-1:0] rem_q;
  logic [FW-1:0] quo_q;
  logic          sat_q;

  logic [PW-1:0] prod_new;
  logic [PW-1:0] prod_best;
  logic [UW:0]   rem2;
  logic          ge;

  assign prod_new  = PW'(num_i) * PW'(best_den_q);
  assign prod_best = PW'(best_num_q) * PW'(den_i);
  assign rem2      = {rem_q, 1'b0};
  assign ge        = rem2 >= {1'b0, best_den_q};

  // Keep best fraction, then shift out quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_num_q <= '0;
      best_den_q <= UW'(1);
      rem_q      <= '0;
      quo_q      <= '0;
      sat_q      <= 1'b0;
    end else if (ctrl_i.init) begin
      best_num_q <= '0;
      best_den_q <= UW'(1);
    end else if (ctrl_i.cmp) begin
      if (prod_new > prod_best) begin
        best_num_q <= num_i;
        best_den_q <= den_i;
      end
    end else if (ctrl_i.div_init) begin
      rem_q <= UW'(best_num_q);
      quo_q <= '0;
      sat_q <= UW'(best_num_q) >= best_den_q;
    end else if (ctrl_i.div_step) begin
      rem_q <= ge ? UW'(rem2 - {1'b0, best_den_q}) : rem2[UW-1:0];
      quo_q <= {quo_q[FW-2:0], ge};
    end
  end

  // Ratio of one or more saturates to 1.0
  assign quo_o = sat_q ? mts_pkg::SIM_W'(1 << FW) : mts_pkg::SIM_W'(quo_q);

endmodule

// ----- design/max_tanimoto_similarity_core.sv -----
`timescale 1ns / 1ps
// Max Tanimoto similarity core: clear, target chunk and query chunk transactions
// are accepted only in the idle state. A query's last chunk starts a capture, a
// walk down the cell chain and then a serial divide of the best fraction. No input
// is taken until the result is registered, so a result still waiting for the sink
// holds input.
// Reset empties the target store; no clearing pass is needed.
module max_tanimoto_similarity_core #(
  parameter int unsigned CHUNKS      = mts_pkg::CHUNKS_DEF,
  parameter int unsigned MAX_TARGETS = mts_pkg::MAX_TARGETS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mts_in_if.sink     in_i,
  mts_out_if.source  out_o
);

  localparam int unsigned CIW  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned CXW  = $clog2(CHUNKS + 1);
  localparam int unsigned TTW  = $clog2(MAX_TARGETS + 1);
  localparam int unsigned AW   = $clog2(CHUNKS * mts_pkg::WORD_W + 1);
  localparam int unsigned UW   = mts_pkg::UNION_W;
  localparam int unsigned NW   = $clog2(MAX_TARGETS + mts_pkg::FRAC_W + 2);

  mts_pkg::state_e state_q, state_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic [TTW-1:0]  total_q, total_d;
  logic [CXW-1:0]  load_idx_q, load_idx_d;
  logic [CXW-1:0]  qidx_q, qidx_d;
  logic            drop_q, drop_d;
  logic [mts_pkg::COUNT_W-1:0] qcount_q, qcount_d;
  logic            out_valid_q, out_valid_d;
  mts_pkg::out_item_t out_data_q, out_data_d;

  mts_pkg::cell_ctrl_t cctrl;
  mts_pkg::fin_ctrl_t  fctrl;
  logic                in_acc;
  logic                room;
  logic [mts_pkg::SIM_W-1:0] quo;

  logic [AW-1:0] num_c [MAX_TARGETS+1];
  logic [UW-1:0] den_c [MAX_TARGETS+1];

  assign in_acc = in_i.valid && in_i.ready;
  assign room   = total_q < TTW'(MAX_TARGETS);

  // Chain of target cells; the far end feeds a zero fraction
  assign num_c[MAX_TARGETS] = '0;
  assign den_c[MAX_TARGETS] = UW'(1);

  for (genvar i = 0; i < MAX_TARGETS; i++) begin : g_cell
    mts_cell #(.CHUNKS(CHUNKS)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cctrl),
      .sel_i    (total_q == TTW'(i)),
      .active_i (TTW'(i) < total_q),
      .wr_idx_i (load_idx_q[CIW-1:0]),
      .rd_idx_i (qidx_q[CIW-1:0]),
      .word_i   (in_i.data.word),
      .count_i  (in_i.data.bit_count),
      .qcount_i (qcount_q),
      .num_i    (num_c[i+1]),
      .den_i    (den_c[i+1]),
      .num_o    (num_c[i]),
      .den_o    (den_c[i])
    );
  end

  mts_finish #(.AW(AW)) u_finish (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fctrl),
    .num_i  (num_c[0]),
    .den_i  (den_c[0]),
    .quo_o  (quo)
  );

  // Sequencer: transaction decode, chain walk and divide
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    load_idx_d  = load_idx_q;
    qidx_d      = qidx_q;
    drop_d      = drop_q;
    qcount_d    = qcount_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    cctrl       = '0;
    fctrl       = '0;
    in_i.ready  = 1'b0;

    unique case (state_q)
      mts_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_acc) begin
          unique case (in_i.data.op)
            mts_pkg::OP_CLEAR: begin
              cctrl.clear = 1'b1;
              total_d     = '0;
              load_idx_d  = '0;
              qidx_d      = '0;
              drop_d      = 1'b0;
            end
            mts_pkg::OP_TARGET: begin
              if (!room) drop_d = 1'b1;
              if (load_idx_q < CXW'(CHUNKS)) begin
                cctrl.wr_word = room;
                load_idx_d    = load_idx_q + CXW'(1);
              end else begin
                drop_d = 1'b1;
              end
              if (in_i.data.last) begin
                if (room) begin
                  cctrl.wr_count = 1'b1;
                  total_d        = total_q + TTW'(1);
                end
                load_idx_d = '0;
              end
            end
            mts_pkg::OP_QUERY: begin
              if (qidx_q < CXW'(CHUNKS)) begin
                cctrl.query = 1'b1;
                qidx_d      = qidx_q + CXW'(1);
              end else begin
                drop_d = 1'b1;
              end
              if (in_i.data.last) begin
                qidx_d   = '0;
                qcount_d = in_i.data.bit_count;
                state_d  = mts_pkg::ST_CAPT;
              end
            end
            default: ;
          endcase
        end
      end
      mts_pkg::ST_CAPT: begin
        cctrl.capture = 1'b1;
        fctrl.init    = 1'b1;
        cnt_d         = '0;
        state_d       = mts_pkg::ST_SHIFT;
      end
      mts_pkg::ST_SHIFT: begin
        fctrl.cmp   = 1'b1;
        cctrl.shift = 1'b1;
        cnt_d       = cnt_q + NW'(1);
        if (cnt_q == NW'(MAX_TARGETS - 1)) begin
          cnt_d   = '0;
          state_d = mts_pkg::ST_DIV;
        end
      end
      mts_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          fctrl.div_init = 1'b1;
          cnt_d          = cnt_q + NW'(1);
        end else if (cnt_q <= NW'(mts_pkg::FRAC_W)) begin
          fctrl.div_step = 1'b1;
          cnt_d          = cnt_q + NW'(1);
        end else if (!out_valid_q || out_o.ready) begin
          out_valid_d                 = 1'b1;
          out_data_d.similarity       = quo;
          out_data_d.targets_compared = mts_pkg::TOTAL_W'(total_q);
          out_data_d.dropped          = drop_q;
          cnt_d                       = '0;
          state_d                     = mts_pkg::ST_IDLE;
        end
      end
      default: state_d = mts_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mts_pkg::ST_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      load_idx_q  <= '0;
      qidx_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      load_idx_q  <= load_idx_d;
      qidx_q      <= qidx_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    qcount_q   <= qcount_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Checks
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TTW'(MAX_TARGETS))
    else $error("target total beyond capacity");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qidx_q <= CXW'(CHUNKS)) && (load_idx_q <= CXW'(CHUNKS)))
    else $error("chunk index beyond saturation");

  a_query_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.data.op == mts_pkg::OP_QUERY) && in_i.data.last)
      |=> (state_q == mts_pkg::ST_CAPT))
    else $error("query end did not start capture");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == mts_pkg::ST_DIV))
    else $error("result raised outside divide");

endmodule
